// File: hw/rtl/i2cms_pkg.sv
package i2cms_pkg;

    localparam int WRITE_BUF_DEPTH_DEF = 16;
    localparam int BUF_IDX_W           = 4;
    localparam int COUNT_W             = 5;

    // request types
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_BEGIN = 2'd1;
    localparam logic [1:0] REQ_EVENT = 2'd2;

    // engine commands
    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_SEND    = 3'd2;
    localparam logic [2:0] CMD_RX_ACK  = 3'd3;
    localparam logic [2:0] CMD_RX_NACK = 3'd4;
    localparam logic [2:0] CMD_RESTART = 3'd5;
    localparam logic [2:0] CMD_STOP    = 3'd6;

    // engine status codes (after masking)
    localparam logic [7:0] ST_MASK     = 8'hF8;
    localparam logic [7:0] ST_START    = 8'h08;
    localparam logic [7:0] ST_SLAW_ACK = 8'h18;
    localparam logic [7:0] ST_DATA_ACK = 8'h28;
    localparam logic [7:0] ST_SLAR_ACK = 8'h40;
    localparam logic [7:0] ST_RX_ACK   = 8'h50;
    localparam logic [7:0] ST_RX_NACK  = 8'h58;
    localparam logic       READ_BIT    = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_START   = 3'd1,
        PH_SLAW    = 3'd2,
        PH_WDATA   = 3'd3,
        PH_RESTART = 3'd4,
        PH_SLAR    = 3'd5,
        PH_RDATA   = 3'd6
    } phase_t;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [6:0]           slave_addr;
        logic [COUNT_W-1:0]   write_count;
        logic [7:0]           read_count;
        logic [BUF_IDX_W-1:0] buf_index;
        logic [7:0]           buf_byte;
        logic [7:0]           bus_status;
        logic [7:0]           received_byte;
    } req_t;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [7:0] rx_index;
        logic       done_res;
        logic       error;
    } res_t;

endpackage

// File: hw/rtl/i2cms_if.sv
interface i2cms_req_if;
    import i2cms_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [1:0]           req_type;
    logic [6:0]           slave_addr;
    logic [COUNT_W-1:0]   write_count;
    logic [7:0]           read_count;
    logic [BUF_IDX_W-1:0] buf_index;
    logic [7:0]           buf_byte;
    logic [7:0]           bus_status;
    logic [7:0]           received_byte;

    modport source (
        output valid, req_type, slave_addr, write_count, read_count,
               buf_index, buf_byte, bus_status, received_byte,
        input  ready
    );
    modport sink (
        input  valid, req_type, slave_addr, write_count, read_count,
               buf_index, buf_byte, bus_status, received_byte,
        output ready
    );
endinterface

interface i2cms_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [7:0] rx_index;
    logic       done_res;
    logic       error;

    modport source (
        output valid, command, tx_byte, rx_valid, rx_byte, rx_index, done_res, error,
        input  ready
    );
    modport sink (
        input  valid, command, tx_byte, rx_valid, rx_byte, rx_index, done_res, error,
        output ready
    );
endinterface

// File: hw/rtl/i2cms_wbuf.sv
module i2cms_wbuf #(
    parameter int WRITE_BUF_DEPTH = i2cms_pkg::WRITE_BUF_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [i2cms_pkg::BUF_IDX_W-1:0] wr_idx,
    input  logic [7:0]                      wr_data,
    input  logic [7:0]                      rd_cursor,
    output logic [7:0]                      rd_byte
);
    import i2cms_pkg::*;

    // only slots reachable by the load index get storage
    localparam int ENTRIES = (WRITE_BUF_DEPTH < (2 ** BUF_IDX_W)) ?
                             WRITE_BUF_DEPTH : (2 ** BUF_IDX_W);
    localparam int IDX_W   = $clog2(ENTRIES);

    logic [7:0] slot_reg [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en && (32'(wr_idx) < ENTRIES))
        begin
            slot_reg[wr_idx[IDX_W-1:0]] <= wr_data;
        end
    end

    assign rd_byte = (32'(rd_cursor) < ENTRIES) ? slot_reg[rd_cursor[IDX_W-1:0]] : 8'd0;

endmodule

// File: hw/rtl/i2cms_ctrl.sv
module i2cms_ctrl #(
    parameter int WRITE_BUF_DEPTH = i2cms_pkg::WRITE_BUF_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  i2cms_pkg::req_t   item,
    input  logic [7:0]        buf_byte,
    output logic [7:0]        buf_cursor,
    output i2cms_pkg::res_t   result
);
    import i2cms_pkg::*;

    localparam logic [8:0] DEPTH_V = 9'(WRITE_BUF_DEPTH);

    phase_t             phase_reg,  phase_next;
    logic [6:0]         addr_reg,   addr_next;
    logic [COUNT_W-1:0] wtot_reg,   wtot_next;
    logic [7:0]         rtot_reg,   rtot_next;
    logic [7:0]         cur_reg,    cur_next;

    logic [7:0]         cur_inc;
    logic [7:0]         expect_st;
    logic               status_ok;
    logic               rx_last;
    logic               rx_last_inc;
    logic [COUNT_W-1:0] wc_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            addr_reg  <= '0;
            wtot_reg  <= '0;
            rtot_reg  <= '0;
            cur_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
            wtot_reg  <= wtot_next;
            rtot_reg  <= rtot_next;
            cur_reg   <= cur_next;
        end
    end

    assign cur_inc     = cur_reg + 8'd1;
    assign rx_last     = ({1'b0, cur_reg} + 9'd1) == {1'b0, rtot_reg};
    assign rx_last_inc = ({1'b0, cur_inc} + 9'd1) == {1'b0, rtot_reg};
    assign wc_sat      = ({4'd0, item.write_count} > DEPTH_V) ?
                         DEPTH_V[COUNT_W-1:0] : item.write_count;
    assign buf_cursor  = (phase_reg == PH_SLAW) ? 8'd0 : cur_inc;
    assign status_ok   = (item.bus_status & ST_MASK) == expect_st;

    always_comb
    begin
        case (phase_reg)
            PH_START:   expect_st = ST_START;
            PH_SLAW:    expect_st = ST_SLAW_ACK;
            PH_WDATA:   expect_st = ST_DATA_ACK;
            PH_RESTART: expect_st = ST_START;
            PH_SLAR:    expect_st = ST_SLAR_ACK;
            default:    expect_st = rx_last ? ST_RX_NACK : ST_RX_ACK;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        addr_next  = addr_reg;
        wtot_next  = wtot_reg;
        rtot_next  = rtot_reg;
        cur_next   = cur_reg;
        result     = '0;

        case (item.req_type)
            REQ_BEGIN:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    addr_next      = item.slave_addr;
                    wtot_next      = wc_sat;
                    rtot_next      = item.read_count;
                    cur_next       = 8'd0;
                    result.command = CMD_START;
                    phase_next     = PH_START;
                end
            end
            REQ_EVENT:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    if (!status_ok)
                    begin
                        result.done_res = 1'b1;
                        result.error    = 1'b1;
                        phase_next      = PH_IDLE;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_START:
                            begin
                                result.command = CMD_SEND;
                                result.tx_byte = {addr_reg, 1'b0};
                                phase_next     = PH_SLAW;
                            end
                            PH_SLAW, PH_WDATA:
                            begin
                                cur_next = buf_cursor;
                                if (buf_cursor < {3'd0, wtot_reg}
                                    && (phase_reg == PH_WDATA || wtot_reg != '0))
                                begin
                                    result.command = CMD_SEND;
                                    result.tx_byte = buf_byte;
                                    phase_next     = PH_WDATA;
                                end
                                else if (rtot_reg != 8'd0)
                                begin
                                    result.command = CMD_RESTART;
                                    phase_next     = PH_RESTART;
                                end
                                else
                                begin
                                    result.command  = CMD_STOP;
                                    result.done_res = 1'b1;
                                    phase_next      = PH_IDLE;
                                end
                            end
                            PH_RESTART:
                            begin
                                result.command = CMD_SEND;
                                result.tx_byte = {addr_reg, READ_BIT};
                                phase_next     = PH_SLAR;
                            end
                            PH_SLAR:
                            begin
                                cur_next       = 8'd0;
                                // cursor restarts at zero: last when one byte wanted
                                result.command = (rtot_reg == 8'd1) ? CMD_RX_NACK : CMD_RX_ACK;
                                phase_next     = PH_RDATA;
                            end
                            default:
                            begin
                                result.rx_valid = 1'b1;
                                result.rx_byte  = item.received_byte;
                                result.rx_index = cur_reg;
                                cur_next        = cur_inc;
                                if (cur_inc >= rtot_reg)
                                begin
                                    result.command  = CMD_STOP;
                                    result.done_res = 1'b1;
                                    phase_next      = PH_IDLE;
                                end
                                else
                                begin
                                    result.command = rx_last_inc ? CMD_RX_NACK : CMD_RX_ACK;
                                    phase_next     = PH_RDATA;
                                end
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                // loads are handled by the buffer; unknown types do nothing
            end
        endcase
    end

endmodule

// File: hw/rtl/i2c_master_transaction_sequencer.sv
// I2C master write-then-read sequencer. It sits above a byte-level I2C engine
// and takes one item per cycle: a write-buffer load, a begin request (device
// address, write count, read count) or an engine completion carrying the status
// byte. Every item yields exactly one result item with the next engine command,
// the byte to send, any received byte with its index, and done/error flags.
// Items are registered on entry, handled by a single pass of compare and
// phase-update logic, and the result lands in an output register, so a result
// is offered once its item has moved from the input register to the output
// register, and a new item can be taken every cycle; the only throttle is the
// downstream ready. A status that does not match the expected code (low three
// bits ignored) ends the transaction with done and error and no stop. Loads
// are accepted at any time, also in the middle of a transaction; begin while
// busy and events while idle are answered with an empty result.
module i2c_master_transaction_sequencer #(
    parameter int WRITE_BUF_DEPTH = i2cms_pkg::WRITE_BUF_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    i2cms_req_if.sink   req,
    i2cms_res_if.source res
);
    import i2cms_pkg::*;

    // input stage
    logic  in_vld_reg;
    req_t  in_item_reg;
    // output stage
    logic  out_vld_reg;
    res_t  out_item_reg;

    logic  advance;
    logic  take;
    res_t  result;
    logic [7:0] buf_rd;
    logic [7:0] buf_cursor;

    // the input stage moves on whenever the output register is free or draining
    assign advance   = in_vld_reg && (!out_vld_reg || res.ready);
    assign req.ready = !in_vld_reg || advance;
    assign take      = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end

            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg <= '{
                req_type:      req.req_type,
                slave_addr:    req.slave_addr,
                write_count:   req.write_count,
                read_count:    req.read_count,
                buf_index:     req.buf_index,
                buf_byte:      req.buf_byte,
                bus_status:    req.bus_status,
                received_byte: req.received_byte
            };
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    // write buffer: loads are stored in order with the other items
    i2cms_wbuf #(
        .WRITE_BUF_DEPTH (WRITE_BUF_DEPTH)
    ) u_wbuf (
        .clk       (clk),
        .wr_en     (advance && (in_item_reg.req_type == REQ_LOAD)),
        .wr_idx    (in_item_reg.buf_index),
        .wr_data   (in_item_reg.buf_byte),
        .rd_cursor (buf_cursor),
        .rd_byte   (buf_rd)
    );

    // phase machine and result formatting
    i2cms_ctrl #(
        .WRITE_BUF_DEPTH (WRITE_BUF_DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .item       (in_item_reg),
        .buf_byte   (buf_rd),
        .buf_cursor (buf_cursor),
        .result     (result)
    );

    assign res.valid    = out_vld_reg;
    assign res.command  = out_item_reg.command;
    assign res.tx_byte  = out_item_reg.tx_byte;
    assign res.rx_valid = out_item_reg.rx_valid;
    assign res.rx_byte  = out_item_reg.rx_byte;
    assign res.rx_index = out_item_reg.rx_index;
    assign res.done_res = out_item_reg.done_res;
    assign res.error    = out_item_reg.error;

endmodule

// File: hw/rtl/i2cms_checker.sv
module i2cms_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [2:0] command,
    input logic [7:0] tx_byte,
    input logic       rx_valid,
    input logic       done_res,
    input logic       error
);
    import i2cms_pkg::*;

    // an error result carries nothing else
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && error |-> done_res && command == CMD_NONE && !rx_valid)
        else $error("error result with command or data");

    // a successful end is always a stop
    a_done_stop: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && done_res && !error |-> command == CMD_STOP)
        else $error("success without stop");

    // received data only comes with a receive or the final stop
    a_rx_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && rx_valid |->
            command == CMD_RX_ACK || command == CMD_RX_NACK || command == CMD_STOP)
        else $error("rx byte with wrong command");

    // tx byte is zero unless sending
    a_tx_send: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && tx_byte != 8'd0 |-> command == CMD_SEND)
        else $error("tx byte outside send");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(command) && $stable(tx_byte))
        else $error("stalled result changed");

endmodule

bind i2c_master_transaction_sequencer i2cms_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .command   (res.command),
    .tx_byte   (res.tx_byte),
    .rx_valid  (res.rx_valid),
    .done_res  (res.done_res),
    .error     (res.error)
);
